// ----- src/upstream_node_selector_macros.svh -----
// Assertion macros shared by the upstream node selector RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef UPSTREAM_NODE_SELECTOR_MACROS_SVH
`define UPSTREAM_NODE_SELECTOR_MACROS_SVH
`ifndef ASSERT_OFF
`define USN_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define USN_ASSERT_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define USN_ASSERT(name, prop, msg)
`define USN_ASSERT_NEVER(name, expr, msg)
`endif
`endif

// ----- src/usn_pkg.sv -----
// Types, constants and codes for the upstream node selector.
// No dependencies; used by usn_table and upstream_node_selector.
`timescale 1ns / 1ps

package usn_pkg;

	localparam int NODES  = 16;
	localparam int NODE_W = $clog2(NODES);
	localparam int CNT_W  = $clog2(NODES + 1);
	localparam int LAT_W  = 30;
	localparam int FCNT_W = 8;

	localparam logic [LAT_W-1:0]  LAT_LIMIT  = 30'd999999999;
	localparam logic [FCNT_W-1:0] FAIL_LIMIT = 8'd2;
	localparam logic [FCNT_W-1:0] FCNT_MAX   = 8'hFF;

	// Request actions.
	localparam logic [1:0] ACT_SELECT  = 2'd0;
	localparam logic [1:0] ACT_CONN_FAIL = 2'd1;
	localparam logic [1:0] ACT_SUCCESS = 2'd2;
	localparam logic [1:0] ACT_PROBE_FAIL = 2'd3;

	// Strategy codes. The spare code behaves as failover.
	localparam logic [1:0] STRAT_FAILOVER = 2'd0;
	localparam logic [1:0] STRAT_LATENCY  = 2'd1;
	localparam logic [1:0] STRAT_RR       = 2'd2;
	localparam logic [1:0] STRAT_UNUSED   = 2'd3;

	// Result source codes.
	localparam logic [2:0] SRC_MANUAL   = 3'd0;
	localparam logic [2:0] SRC_LATENCY  = 3'd1;
	localparam logic [2:0] SRC_RR       = 3'd2;
	localparam logic [2:0] SRC_FIRST    = 3'd3;
	localparam logic [2:0] SRC_FALLBACK = 3'd4;
	localparam logic [2:0] SRC_UPDATE   = 3'd5;

	// Register indexes (word address bits).
	localparam logic [1:0] REG_STRATEGY   = 2'd0;
	localparam logic [1:0] REG_NODE_COUNT = 2'd1;
	localparam logic [1:0] REG_MANUAL     = 2'd2;

	typedef struct packed {
		logic [LAT_W-1:0]  lat;
		logic [FCNT_W-1:0] fcnt;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [NODE_W-1:0] addr;
		entry_t            data;
	} wr_req_t;

endpackage

// ----- src/usn_table.sv -----
// Health table memory: latency and failure count per node, one read port with
// registered data and one write port. Depends on usn_pkg.
`timescale 1ns / 1ps

module usn_table
	import usn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [NODE_W-1:0] rd_addr,
	output entry_t            rd_data,
	input  wr_req_t           wr
);

	entry_t            mem [NODES];
	entry_t            rd_q;
	logic [NODES-1:0]  written_q;
	logic              rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// An entry never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_s1 ? rd_q : '0;

endmodule

// ----- src/upstream_node_selector.sv -----
// Top level of the upstream node selector: request sequencer, alive and known
// bits, configuration registers and result register. Depends on usn_pkg and usn_table.
`timescale 1ns / 1ps

// One request is in flight at a time; a finished result waits in the output
// register while the next request is taken. An update inside the pool reads the
// table on acceptance, writes the entry back and then loads the result; an update
// outside the pool and a select served by the manual override load the result
// directly, and a select resolved by the first alive node passes through the
// first-alive step before the load. Best latency walks the table memory one entry
// per cycle across the pool, then loads the best node, or the first alive node
// when no node qualifies. Round robin first reduces the pointer into the pool
// (only needed after a pool shrink) and then probes one slot per cycle until an
// alive node is found or the pool is exhausted. While a result waits in a stalled
// output register, the next finished request holds in its last step and no
// further request is taken. The health table needs no clearing pass after reset.
module upstream_node_selector
	import usn_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         action,
	input  logic [3:0]         node_index,
	input  logic [29:0]        latency_in,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [3:0]         chosen_node,
	output logic               chosen_alive,
	output logic [2:0]         source,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

`include "upstream_node_selector_macros.svh"

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_UPD   = 3'd1;
	localparam logic [2:0] ST_LAT   = 3'd2;
	localparam logic [2:0] ST_RRMOD = 3'd3;
	localparam logic [2:0] ST_RR    = 3'd4;
	localparam logic [2:0] ST_FIRST = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0]        state_q;
	logic [1:0]        strategy_q;
	logic [4:0]        node_count_q;
	logic [4:0]        manual_q;
	logic [NODES-1:0]  alive_q;
	logic [NODES-1:0]  known_q;
	logic [NODE_W-1:0] rr_q;

	logic [1:0]        act_q;
	logic [NODE_W-1:0] idx_q;
	logic [LAT_W-1:0]  lat_q;

	logic [CNT_W-1:0]  scan_q;
	logic              pend_s1;
	logic [NODE_W-1:0] idx_s1;
	logic [LAT_W-1:0]  best_q;
	logic [NODE_W-1:0] best_i_q;
	logic              found_q;
	logic [NODE_W-1:0] ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [NODE_W-1:0] res_node_q;
	logic              res_alive_q;
	logic [2:0]        res_src_q;
	logic              out_valid_q;
	logic [NODE_W-1:0] out_node_q;
	logic              out_alive_q;
	logic [2:0]        out_src_q;

	logic [CNT_W-1:0]  pool_n;
	logic [NODES-1:0]  pool_mask;
	logic [NODES-1:0]  alive_pool;
	logic [NODE_W-1:0] first_idx;
	logic [CNT_W-1:0]  manual_m;
	logic              manual_ok;
	logic              req_acc;
	logic              cfg_wr;
	logic              load_out;

	logic              tbl_rd_en;
	logic [NODE_W-1:0] tbl_rd_addr;
	entry_t            tbl_rd;
	wr_req_t           tbl_wr;

	logic [FCNT_W-1:0] fc_inc;
	entry_t            upd_ent;
	logic              upd_alive;
	logic              upd_known;
	logic              lat_qual;
	logic [NODE_W-1:0] ptr_next;
	logic [CNT_W-1:0]  rr_diff;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q   <= STRAT_FAILOVER;
			node_count_q <= 5'd1;
			manual_q     <= 5'd0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_STRATEGY:   strategy_q   <= pwdata[1:0];
				REG_NODE_COUNT: node_count_q <= pwdata[4:0];
				REG_MANUAL:     manual_q     <= pwdata[4:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_STRATEGY:   prdata = {30'd0, strategy_q};
			REG_NODE_COUNT: prdata = {27'd0, node_count_q};
			REG_MANUAL:     prdata = {27'd0, manual_q};
			default:        prdata = '0;
		endcase
	end

	// Pool size and derived masks.
	always_comb begin
		if (node_count_q == '0) begin
			pool_n = CNT_W'(1);
		end else if (node_count_q > CNT_W'(NODES)) begin
			pool_n = CNT_W'(NODES);
		end else begin
			pool_n = node_count_q;
		end
		for (int i = 0; i < NODES; i++) begin
			pool_mask[i] = (CNT_W'(i) < pool_n);
		end
		alive_pool = alive_q & pool_mask;
		first_idx = '0;
		for (int i = NODES - 1; i >= 0; i--) begin
			if (alive_pool[i]) begin
				first_idx = NODE_W'(i);
			end
		end
	end

	assign manual_m  = manual_q - 5'd1;
	assign manual_ok = (manual_q != '0) && (manual_m < pool_n)
		&& alive_q[manual_m[NODE_W-1:0]];

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;

	// Table read port: update target on acceptance, scan index during best latency.
	always_comb begin
		tbl_rd_en   = 1'b0;
		tbl_rd_addr = node_index;
		if (state_q == ST_IDLE) begin
			tbl_rd_en = req_acc && (action != ACT_SELECT);
		end else if (state_q == ST_LAT) begin
			tbl_rd_en   = (scan_q < pool_n);
			tbl_rd_addr = scan_q[NODE_W-1:0];
		end
	end

	usn_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (tbl_rd_en),
		.rd_addr (tbl_rd_addr),
		.rd_data (tbl_rd),
		.wr      (tbl_wr)
	);

	// Read-modify-write of one health entry.
	always_comb begin
		fc_inc    = (tbl_rd.fcnt == FCNT_MAX) ? tbl_rd.fcnt : tbl_rd.fcnt + 8'd1;
		upd_ent   = tbl_rd;
		upd_alive = alive_q[idx_q];
		upd_known = known_q[idx_q];
		case (act_q)
			ACT_SUCCESS: begin
				upd_ent.lat  = lat_q;
				upd_ent.fcnt = '0;
				upd_alive    = 1'b1;
				upd_known    = 1'b1;
			end
			ACT_CONN_FAIL: begin
				upd_ent.fcnt = fc_inc;
				if (fc_inc >= FAIL_LIMIT) begin
					upd_alive = 1'b0;
				end
			end
			ACT_PROBE_FAIL: begin
				upd_ent.lat  = '0;
				upd_ent.fcnt = fc_inc;
				upd_alive    = 1'b0;
				upd_known    = 1'b0;
			end
			default: ;
		endcase
		tbl_wr.en   = (state_q == ST_UPD);
		tbl_wr.addr = idx_q;
		tbl_wr.data = upd_ent;
	end

	assign lat_qual = pend_s1 && alive_q[idx_s1] && known_q[idx_s1] && (tbl_rd.lat < best_q);
	assign ptr_next = ((CNT_W'(ptr_q) + CNT_W'(1)) == pool_n) ? '0 : ptr_q + NODE_W'(1);
	assign rr_diff  = CNT_W'(rr_q) - pool_n;
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || !rsp_stall);

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			alive_q <= '1;
			known_q <= '1;
			rr_q    <= '0;
			scan_q  <= '0;
			pend_s1 <= 1'b0;
			found_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			pend_s1 <= (state_q == ST_LAT) && (scan_q < pool_n);
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (action != ACT_SELECT) begin
							if (CNT_W'(node_index) >= pool_n) begin
								state_q <= ST_EMIT;
							end else begin
								state_q <= ST_UPD;
							end
						end else if (manual_ok) begin
							state_q <= ST_EMIT;
						end else if (strategy_q == STRAT_LATENCY) begin
							scan_q  <= '0;
							found_q <= 1'b0;
							state_q <= ST_LAT;
						end else if (strategy_q == STRAT_RR) begin
							state_q <= ST_RRMOD;
						end else begin
							state_q <= ST_FIRST;
						end
					end
				end
				ST_UPD: begin
					alive_q[idx_q] <= upd_alive;
					known_q[idx_q] <= upd_known;
					state_q        <= ST_EMIT;
				end
				ST_LAT: begin
					if (scan_q < pool_n) begin
						scan_q <= scan_q + CNT_W'(1);
					end
					if (lat_qual) begin
						found_q <= 1'b1;
					end
					if (scan_q >= pool_n && !pend_s1) begin
						state_q <= found_q ? ST_EMIT : ST_FIRST;
					end
				end
				ST_RRMOD: begin
					if (CNT_W'(rr_q) >= pool_n) begin
						rr_q <= rr_diff[NODE_W-1:0];
					end else begin
						cnt_q   <= '0;
						state_q <= ST_RR;
					end
				end
				ST_RR: begin
					if (alive_q[ptr_q]) begin
						rr_q    <= ptr_next;
						state_q <= ST_EMIT;
					end else if ((cnt_q + CNT_W'(1)) == pool_n) begin
						state_q <= ST_FIRST;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_FIRST: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request fields, scan data and pending result.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			act_q <= action;
			idx_q <= node_index;
			lat_q <= latency_in;
			best_q <= LAT_LIMIT;
			best_i_q <= '0;
			if (action != ACT_SELECT) begin
				res_node_q  <= node_index;
				res_alive_q <= 1'b0;
				res_src_q   <= SRC_UPDATE;
			end else begin
				res_node_q  <= manual_m[NODE_W-1:0];
				res_alive_q <= 1'b1;
				res_src_q   <= SRC_MANUAL;
			end
		end
		if (state_q == ST_LAT) begin
			idx_s1 <= scan_q[NODE_W-1:0];
			if (lat_qual) begin
				best_q   <= tbl_rd.lat;
				best_i_q <= idx_s1;
			end
			res_node_q  <= best_i_q;
			res_alive_q <= 1'b1;
			res_src_q   <= SRC_LATENCY;
		end
		if (state_q == ST_UPD) begin
			res_alive_q <= upd_alive;
		end
		if (state_q == ST_RRMOD) begin
			ptr_q <= rr_q;
		end
		if (state_q == ST_RR) begin
			ptr_q       <= ptr_next;
			res_node_q  <= ptr_q;
			res_alive_q <= 1'b1;
			res_src_q   <= SRC_RR;
		end
		if (state_q == ST_FIRST) begin
			if (alive_pool != '0) begin
				res_node_q  <= first_idx;
				res_alive_q <= 1'b1;
				res_src_q   <= SRC_FIRST;
			end else begin
				res_node_q  <= '0;
				res_alive_q <= alive_q[0];
				res_src_q   <= SRC_FALLBACK;
			end
		end
	end

	// Output register: holds a finished result while the next request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_node_q  <= res_node_q;
			out_alive_q <= res_alive_q;
			out_src_q   <= res_src_q;
		end
	end

	assign rsp_valid    = out_valid_q;
	assign chosen_node  = out_node_q;
	assign chosen_alive = out_alive_q;
	assign source       = out_src_q;

	`USN_ASSERT(a_out_from_emit, $rose(out_valid_q) |-> $past(state_q) == ST_EMIT, "result loaded outside emit")
	`USN_ASSERT(a_rr_ptr_in_pool, state_q == ST_RR |-> CNT_W'(ptr_q) < pool_n, "round robin pointer outside pool")
	`USN_ASSERT(a_scan_in_pool, pend_s1 |-> CNT_W'(idx_s1) < pool_n, "latency scan beyond pool")
	`USN_ASSERT_NEVER(a_chosen_dead, out_valid_q && out_src_q <= SRC_FIRST && !out_alive_q, "selected node not alive")

endmodule
